FILE: rtl/core/stick_eight_way_direction_tracker_assert.svh
// assertion macros used by the checker file
`ifndef STICK_EIGHT_WAY_DIRECTION_TRACKER_ASSERT_SVH
`define STICK_EIGHT_WAY_DIRECTION_TRACKER_ASSERT_SVH

// property checked only while out of reset
`define SEDT_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define SEDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sedt_pkg.sv
// shared constants, codes and slot update function of the direction tracker
package sedt_pkg;

  localparam int FIELD_W   = 16;
  localparam int AXIS_BITS = 16;
  localparam int MAG_W     = AXIS_BITS;
  localparam int SUM_W     = MAG_W + 1;
  localparam int SQ_W      = 2 * MAG_W + 1;
  localparam int DZ_W      = 15;
  localparam int DZ2_W     = 2 * DZ_W;
  localparam int CMP_W     = (SQ_W > DZ2_W) ? SQ_W : DZ2_W;
  localparam int DIR_W     = 4;
  localparam int ACT_W     = 3;
  localparam int BTN_W     = 2;

  localparam int DZ_RESET_INT = 8000;
  localparam logic [DZ_W-1:0]  DZ_RESET  = DZ_W'(DZ_RESET_INT);
  localparam logic [DZ2_W-1:0] DZ2_RESET = DZ2_W'(DZ_RESET_INT * DZ_RESET_INT);

  typedef enum logic [DIR_W-1:0] {
    DIR_CENTER     = 4'd0,
    DIR_UP         = 4'd1,
    DIR_UP_RIGHT   = 4'd2,
    DIR_RIGHT      = 4'd3,
    DIR_DOWN_RIGHT = 4'd4,
    DIR_DOWN       = 4'd5,
    DIR_DOWN_LEFT  = 4'd6,
    DIR_LEFT       = 4'd7,
    DIR_UP_LEFT    = 4'd8
  } dir_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_PRESS   = 3'd1,
    ACT_HOLD    = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_SWITCH  = 3'd4
  } act_t;

  typedef logic [BTN_W-1:0] btn_t;

  localparam btn_t BTN_NONE = 2'd0;
  localparam btn_t VB_UP    = 2'd1;
  localparam btn_t VB_DOWN  = 2'd2;
  localparam btn_t HB_LEFT  = 2'd1;
  localparam btn_t HB_RIGHT = 2'd2;

  typedef struct packed {
    act_t act;
    btn_t btn;
    btn_t held;
  } slot_t;

  // one virtual button slot: press, hold, release or switch
  function automatic slot_t slot_step(btn_t want, btn_t held);
    slot_t res;
    res.act  = ACT_NONE;
    res.btn  = BTN_NONE;
    res.held = held;
    if (want != BTN_NONE && held == BTN_NONE) begin
      res.act  = ACT_PRESS;
      res.btn  = want;
      res.held = want;
    end else if (want == BTN_NONE && held != BTN_NONE) begin
      res.act  = ACT_RELEASE;
      res.btn  = held;
      res.held = BTN_NONE;
    end else if (want != BTN_NONE && held == want) begin
      res.act  = ACT_HOLD;
      res.btn  = want;
    end else if (want != BTN_NONE) begin
      res.act  = ACT_SWITCH;
      res.btn  = want;
      res.held = want;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/sedt_sample_if.sv
// sample channel: two axis values and the pass-through flag
interface sedt_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [sedt_pkg::FIELD_W-1:0] x_value;
  logic signed [sedt_pkg::FIELD_W-1:0] y_value;
  logic                                ignore_sets;

  modport source (output valid, output x_value, output y_value, output ignore_sets,
                  input ready);
  modport sink   (input valid, input x_value, input y_value, input ignore_sets,
                  output ready);
endinterface

FILE: rtl/core/sedt_result_if.sv
// result channel: direction, activity pulses and button slot events
interface sedt_result_if;
  logic                         valid;
  logic                         ready;
  sedt_pkg::dir_t               direction;
  logic                         stick_active;
  logic                         became_active;
  logic                         became_released;
  sedt_pkg::act_t               vert_action;
  logic [sedt_pkg::BTN_W-1:0]   vert_button;
  sedt_pkg::act_t               horiz_action;
  logic [sedt_pkg::BTN_W-1:0]   horiz_button;
  logic                         sets_flag_out;

  modport source (output valid, output direction, output stick_active,
                  output became_active, output became_released,
                  output vert_action, output vert_button,
                  output horiz_action, output horiz_button,
                  output sets_flag_out, input ready);
  modport sink   (input valid, input direction, input stick_active,
                  input became_active, input became_released,
                  input vert_action, input vert_button,
                  input horiz_action, input horiz_button,
                  input sets_flag_out, output ready);
endinterface

FILE: rtl/core/stick_eight_way_direction_tracker.sv
// eight-way stick direction tracker with radial dead zone and button slot events
//
// Takes one (x, y) sample beat per clock and returns one result beat per sample, in
// order. A sample is centered when x*x + y*y <= dead_zone^2; otherwise it is placed in
// one of eight 45-degree sectors (negative y is up, positive x is right) by exact
// integer tests on a = |x|, b = |y|: vertical when (a+b)^2 < 2b^2, horizontal when
// (a+b)^2 < 2a^2, diagonal otherwise. The tracker keeps an active flag and one held
// vertical and one held horizontal virtual button, and reports press, hold, release
// or switch for each slot. Throughput is one sample per cycle while out_ch.ready
// keeps the result register free; a sample passes the input register, then the
// result register, whose beat stays offered while stalled. The squares (a*a, b*b,
// (a+b)^2), the dead zone test and the sector logic sit between the two registers, so
// the longest path is one 17-bit square followed by a 33-bit compare. dead_zone^2 is
// loaded into its register from cfg_wdata at the write edge, so a sample accepted at
// or after that edge sees the new radius. Only the low AXIS_BITS bits of each axis
// field are used, sign-extended from the top one of them.
module stick_eight_way_direction_tracker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [sedt_pkg::DZ_W-1:0]  cfg_wdata,
  sedt_sample_if.sink                in_ch,
  sedt_result_if.source              out_ch
);
  import sedt_pkg::*;

  // configuration: square of the dead zone radius
  logic [DZ2_W-1:0] dz2_r;

  // stage 0: input register with magnitudes and signs
  logic             v0_r;
  logic [MAG_W-1:0] a0_r, b0_r;
  logic             xpos0_r, yneg0_r, flag0_r;

  // stage 1: result register
  logic             v1_r;
  dir_t             dir_out_r;
  logic             active_out_r, rose_r, fell_r, flag1_r;
  act_t             va_r, ha_r;
  btn_t             vb_r, hb_r;

  // tracked state
  logic             active_r;
  btn_t             vheld_r, hheld_r;
  dir_t             cur_dir_r;

  // flow control: each stage moves on when the one after it has room
  logic             free1, free0;
  logic             load0, load1;

  assign free1 = !v1_r || out_ch.ready;
  assign free0 = !v0_r || free1;
  assign load0 = in_ch.valid && free0;
  assign load1 = v0_r && free1;
  assign in_ch.ready = free0;

  // input side: two's complement magnitude of the low axis bits
  logic [MAG_W-1:0] x_raw, y_raw, x_mag, y_mag;
  logic             x_neg, y_neg, x_pos;

  always_comb begin
    x_raw = in_ch.x_value[AXIS_BITS-1:0];
    y_raw = in_ch.y_value[AXIS_BITS-1:0];
    x_neg = x_raw[MAG_W-1];
    y_neg = y_raw[MAG_W-1];
    x_pos = !x_neg && (x_raw != '0);
    x_mag = x_neg ? ((~x_raw) + MAG_W'(1)) : x_raw;
    y_mag = y_neg ? ((~y_raw) + MAG_W'(1)) : y_raw;
  end

  // the three squares, side by side
  logic [SUM_W-1:0] ab_sum;
  logic [SQ_W-1:0]  a2_sq, b2_sq, s_sq;

  always_comb begin
    ab_sum = SUM_W'(a0_r) + SUM_W'(b0_r);
    a2_sq  = SQ_W'(a0_r) * SQ_W'(a0_r);
    b2_sq  = SQ_W'(b0_r) * SQ_W'(b0_r);
    s_sq   = SQ_W'(ab_sum) * SQ_W'(ab_sum);
  end

  // dead zone test, sector, state and slot events
  logic [CMP_W-1:0] rad2;
  logic [SQ_W-1:0]  twice_a2, twice_b2;
  logic             outside, is_vert, is_horiz;
  dir_t             sector;
  logic             run;
  logic             active_nxt, rose_nxt, fell_nxt;
  dir_t             cur_dir_nxt;
  btn_t             want_v, want_h;
  slot_t            vslot, hslot;
  act_t             va_nxt, ha_nxt;
  btn_t             vb_nxt, hb_nxt, vheld_nxt, hheld_nxt;

  always_comb begin
    // magnitude test against the squared radius
    rad2     = CMP_W'(a2_sq) + CMP_W'(b2_sq);
    outside  = rad2 > CMP_W'(dz2_r);
    // squares never reach the top bit, so doubling cannot overflow
    twice_a2 = a2_sq << 1;
    twice_b2 = b2_sq << 1;
    is_vert  = s_sq < twice_b2;
    is_horiz = s_sq < twice_a2;

    if (is_vert) begin
      sector = yneg0_r ? DIR_UP : DIR_DOWN;
    end else if (is_horiz) begin
      sector = xpos0_r ? DIR_RIGHT : DIR_LEFT;
    end else if (xpos0_r) begin
      sector = yneg0_r ? DIR_UP_RIGHT : DIR_DOWN_RIGHT;
    end else begin
      sector = yneg0_r ? DIR_UP_LEFT : DIR_DOWN_LEFT;
    end

    // activity transitions
    active_nxt  = active_r;
    cur_dir_nxt = cur_dir_r;
    rose_nxt    = 1'b0;
    fell_nxt    = 1'b0;
    run         = active_r;
    if (outside && !active_r) begin
      active_nxt = 1'b1;
      rose_nxt   = 1'b1;
      run        = 1'b1;
    end else if (!outside && active_r) begin
      active_nxt  = 1'b0;
      cur_dir_nxt = DIR_CENTER;
      fell_nxt    = 1'b1;
    end

    // wanted buttons for this sector, none when centered
    want_v = BTN_NONE;
    want_h = BTN_NONE;
    if (run && outside) begin
      cur_dir_nxt = sector;
      case (sector)
        DIR_UP_LEFT, DIR_UP, DIR_UP_RIGHT:       want_v = VB_UP;
        DIR_DOWN_RIGHT, DIR_DOWN, DIR_DOWN_LEFT: want_v = VB_DOWN;
        default:                                 want_v = BTN_NONE;
      endcase
      case (sector)
        DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT: want_h = HB_RIGHT;
        DIR_DOWN_LEFT, DIR_LEFT, DIR_UP_LEFT:    want_h = HB_LEFT;
        default:                                 want_h = BTN_NONE;
      endcase
    end

    vslot = slot_step(want_v, vheld_r);
    hslot = slot_step(want_h, hheld_r);

    // centered and already inactive: no slot events at all
    if (run) begin
      va_nxt    = vslot.act;
      vb_nxt    = vslot.btn;
      vheld_nxt = vslot.held;
      ha_nxt    = hslot.act;
      hb_nxt    = hslot.btn;
      hheld_nxt = hslot.held;
    end else begin
      va_nxt    = ACT_NONE;
      vb_nxt    = BTN_NONE;
      vheld_nxt = vheld_r;
      ha_nxt    = ACT_NONE;
      hb_nxt    = BTN_NONE;
      hheld_nxt = hheld_r;
    end
  end

  // control state, configuration and tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz2_r       <= DZ2_RESET;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      active_r    <= 1'b0;
      vheld_r     <= BTN_NONE;
      hheld_r     <= BTN_NONE;
      cur_dir_r   <= DIR_CENTER;
    end else begin
      // squared radius taken straight from the write data
      if (cfg_we) begin
        dz2_r <= DZ2_W'(cfg_wdata) * DZ2_W'(cfg_wdata);
      end

      if (free0) begin
        v0_r <= in_ch.valid;
      end
      if (free1) begin
        v1_r <= v0_r;
      end

      if (load1) begin
        active_r  <= active_nxt;
        vheld_r   <= vheld_nxt;
        hheld_r   <= hheld_nxt;
        cur_dir_r <= cur_dir_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load0) begin
      a0_r    <= x_mag;
      b0_r    <= y_mag;
      xpos0_r <= x_pos;
      yneg0_r <= y_neg;
      flag0_r <= in_ch.ignore_sets;
    end
    if (load1) begin
      dir_out_r    <= cur_dir_nxt;
      active_out_r <= active_nxt;
      rose_r       <= rose_nxt;
      fell_r       <= fell_nxt;
      va_r         <= va_nxt;
      vb_r         <= vb_nxt;
      ha_r         <= ha_nxt;
      hb_r         <= hb_nxt;
      flag1_r      <= flag0_r;
    end
  end

  assign out_ch.valid           = v1_r;
  assign out_ch.direction       = dir_out_r;
  assign out_ch.stick_active    = active_out_r;
  assign out_ch.became_active   = rose_r;
  assign out_ch.became_released = fell_r;
  assign out_ch.vert_action     = va_r;
  assign out_ch.vert_button     = vb_r;
  assign out_ch.horiz_action    = ha_r;
  assign out_ch.horiz_button    = hb_r;
  assign out_ch.sets_flag_out   = flag1_r;

endmodule

FILE: rtl/core/sedt_checker.sv
// port-level checker for the direction tracker and its bind
`include "stick_eight_way_direction_tracker_assert.svh"

module sedt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sedt_pkg::DIR_W-1:0] direction,
  input logic                       stick_active,
  input logic                       became_active,
  input logic                       became_released,
  input logic [sedt_pkg::ACT_W-1:0] vert_action,
  input logic [sedt_pkg::ACT_W-1:0] horiz_action
);
  import sedt_pkg::*;

  // no result beat right after reset
  `SEDT_ASSERT_ALWAYS(a_rst_no_valid, clk, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result beat stays offered
  `SEDT_ASSERT_RUN(a_valid_holds, clk, rst_n, out_valid && !out_ready |=> out_valid, "valid dropped while stalled")

  // inactive stick always reports centered
  `SEDT_ASSERT_RUN(a_idle_center, clk, rst_n, out_valid && !stick_active |-> direction == DIR_CENTER, "inactive but not centered")

  // release pulse only on an inactive, centered beat
  `SEDT_ASSERT_RUN(a_release_state, clk, rst_n, out_valid && became_released |-> !stick_active && !became_active, "bad release beat")

  // leaving the dead zone starts from no held buttons
  `SEDT_ASSERT_RUN(a_rise_press, clk, rst_n, out_valid && became_active |-> (vert_action == ACT_NONE || vert_action == ACT_PRESS) && (horiz_action == ACT_NONE || horiz_action == ACT_PRESS), "hold or switch on activation")

endmodule

bind stick_eight_way_direction_tracker sedt_checker u_sedt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .direction       (out_ch.direction),
  .stick_active    (out_ch.stick_active),
  .became_active   (out_ch.became_active),
  .became_released (out_ch.became_released),
  .vert_action     (out_ch.vert_action),
  .horiz_action    (out_ch.horiz_action)
);
